// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/adcspi_pkg.sv -----
// ----------------------------------------------------------------------------
// adcspi_pkg
// Types, register numbers and helper functions of the ADC SPI register block.
// ----------------------------------------------------------------------------
package adcspi_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int NUM_INPUT_CH = 3;

    typedef enum logic [1:0] {
        CMD_BYTE   = 2'd0,
        CMD_CS_ON  = 2'd1,
        CMD_CS_OFF = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_READ  = 2'd1,
        PH_WRITE = 2'd2
    } t_phase;

    localparam logic [2:0] REG_STATUS    = 3'd0;
    localparam logic [2:0] REG_MODE      = 3'd1;
    localparam logic [2:0] REG_CONFIG    = 3'd2;
    localparam logic [2:0] REG_DATA      = 3'd3;
    localparam logic [2:0] REG_ID        = 3'd4;
    localparam logic [2:0] REG_IO        = 3'd5;
    localparam logic [2:0] REG_OFFSET    = 3'd6;
    localparam logic [2:0] REG_FULLSCALE = 3'd7;

    localparam logic [7:0]             IDLE_BYTE      = 8'hFF;
    localparam logic [7:0]             ID_RESET       = 8'd74;
    localparam logic [15:0]            MODE_RESET     = 16'h000A;
    localparam logic [15:0]            CONFIG_RESET   = 16'h0710;
    localparam logic [15:0]            OFFSET_RESET   = 16'h8000;
    localparam logic [15:0]            FULLSCALE_RESET = 16'h5540;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_RESET   = 16'h8000;

    typedef struct packed {
        logic [1:0]             cmd;
        logic [7:0]             mosi_byte;
        logic [SAMPLE_BITS-1:0] sample_ch2;
        logic [SAMPLE_BITS-1:0] sample_ch1;
        logic [SAMPLE_BITS-1:0] sample_ch0;
        logic                   samples_valid;
    } t_item;

    typedef struct packed {
        logic [7:0] miso_byte;
        logic [1:0] phase;
    } t_result;

    // Byte count of a register.
    function automatic logic [1:0] reg_bytes(input logic [2:0] r);
        logic [1:0] n;
        case (r)
            REG_STATUS, REG_ID, REG_IO: begin
                n = 2'd1;
            end
            default: begin
                n = 2'd2;
            end
        endcase
        return n;
    endfunction

    // Byte idx of a register value, most significant first, idle byte past the end.
    function automatic logic [7:0] sel_byte(input logic [2:0] r, input logic [1:0] idx,
                                            input logic [15:0] val);
        logic [1:0] n;
        logic [7:0] b;
        n = reg_bytes(r);
        if (idx >= n) begin
            b = IDLE_BYTE;
        end else if (n == 2'd2 && idx == 2'd0) begin
            b = val[15:8];
        end else begin
            b = val[7:0];
        end
        return b;
    endfunction

endpackage

// ----- src/adc_spi_register_interface_top.sv -----
// ----------------------------------------------------------------------------
// adc_spi_register_interface_top
// Byte-level slave of an ADC SPI register interface.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (s_axis) carries one event per item: a received byte, chip
//   select asserted or chip select deasserted, with the live channel samples.
//   Master stream (m_axis) returns exactly one result per item: the byte to
//   shift out next on MISO and the transfer phase after the event.
//   The cfg channel writes the identification value; it is always ready and
//   is meant to be used while no item is in flight.
//   Path: an accepted item waits in the input register, passes the core's
//   combinational step and is stored in the result register, from which it
//   leaves when m_axis is ready.
//   Throughput: one item per cycle while m_axis is not stalled; the whole step
//   is one pass of the core's combinational logic between the two registers.
//   Reset: synchronous, active low; returns all registers to their reset
//   values, the transfer to idle and MISO to 0xFF.
//   Stall: while m_axis is stalled the result holds; one more item is taken
//   into the input register, then s_axis tready drops until the result leaves.
// ----------------------------------------------------------------------------
module adc_spi_register_interface_top #(
    parameter int NUM_CHANNELS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,       // id_value
    // input items
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,   // mosi_byte[7:0], sample_ch0[23:8],
                                          // sample_ch1[39:24], sample_ch2[55:40]
    input  logic [2:0]  i_s_axis_tuser,   // cmd[1:0], samples_valid[2]
    // result items
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // miso_byte[7:0]
    output logic [1:0]  o_m_axis_tuser    // phase[1:0]
);
    import adcspi_pkg::*;

    logic    w_in_valid;
    t_item   w_item;
    logic    w_out_valid;
    logic    w_advance;
    t_result w_step_result;
    t_result w_out_result;

    // Step the core whenever an item waits and the result register is free or emptying.
    assign w_advance = w_in_valid && (!w_out_valid || i_m_axis_tready);

    assign o_cfg_ready = 1'b1;

    adcspi_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .i_data    (i_s_axis_tdata),
        .i_user    (i_s_axis_tuser),
        .i_advance (w_advance),
        .o_ready   (o_s_axis_tready),
        .o_valid   (w_in_valid),
        .o_item    (w_item)
    );

    adcspi_core #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_step     (w_advance),
        .i_item     (w_item),
        .o_result   (w_step_result)
    );

    adcspi_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance),
        .i_result (w_step_result),
        .i_ready  (i_m_axis_tready),
        .o_valid  (w_out_valid),
        .o_result (w_out_result)
    );

    assign o_m_axis_tvalid = w_out_valid;
    assign o_m_axis_tdata  = w_out_result.miso_byte;
    assign o_m_axis_tuser  = w_out_result.phase;

endmodule

// ----- src/adcspi_in_reg.sv -----
// ----------------------------------------------------------------------------
// adcspi_in_reg
// Input register: holds one accepted item until the core consumes it.
// ----------------------------------------------------------------------------
module adcspi_in_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [55:0]         i_data,
    input  logic [2:0]          i_user,
    input  logic                i_advance,
    output logic                o_ready,
    output logic                o_valid,
    output adcspi_pkg::t_item   o_item
);
    import adcspi_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item.cmd           <= i_user[1:0];
            r_item.samples_valid <= i_user[2];
            r_item.mosi_byte     <= i_data[7:0];
            r_item.sample_ch0    <= i_data[23:8];
            r_item.sample_ch1    <= i_data[39:24];
            r_item.sample_ch2    <= i_data[55:40];
        end
    end

endmodule

// ----- src/adcspi_core.sv -----
// ----------------------------------------------------------------------------
// adcspi_core
// Transfer state, register file and sample store; computes one step per item.
// ----------------------------------------------------------------------------
module adcspi_core #(
    parameter int NUM_CHANNELS = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_step,
    input  adcspi_pkg::t_item   i_item,
    output adcspi_pkg::t_result o_result
);
    import adcspi_pkg::*;

    logic [7:0]             r_id;
    t_phase                 r_phase,  n_phase;
    logic [2:0]             r_cur,    n_cur;
    logic [1:0]             r_bi,     n_bi;
    logic [1:0]             r_bt,     n_bt;
    logic [15:0]            r_acc,    n_acc;
    logic                   r_pend,   n_pend;
    logic [2:0]             r_paddr,  n_paddr;
    logic [1:0]             r_pi,     n_pi;
    logic [7:0]             r_out,    n_out;
    logic [15:0]            r_mode,   n_mode;
    logic [15:0]            r_config, n_config;
    logic [7:0]             r_io,     n_io;
    logic [15:0]            r_offset, n_offset;
    logic [15:0]            r_fs,     n_fs;
    logic [SAMPLE_BITS-1:0] r_store [NUM_CHANNELS];
    logic [SAMPLE_BITS-1:0] n_store [NUM_CHANNELS];

    logic [SAMPLE_BITS-1:0] w_in_samples [NUM_INPUT_CH];
    logic [15:0]            w_val [8];
    logic [15:0]            w_chan_val;
    logic                   w_resume;
    logic                   w_latch;
    logic [7:0]             w_b;
    logic [2:0]             w_new_reg;
    logic [1:0]             w_bi_inc;
    logic [1:0]             w_pi_inc;
    logic [1:0]             w_pend_bt;
    logic [15:0]            w_acc_shift;

    assign w_in_samples[0] = i_item.sample_ch0;
    assign w_in_samples[1] = i_item.sample_ch1;
    assign w_in_samples[2] = i_item.sample_ch2;

    assign w_b         = i_item.mosi_byte;
    assign w_new_reg   = w_b[5:3];
    assign w_bi_inc    = r_bi + 2'd1;
    assign w_pi_inc    = r_pi + 2'd1;
    assign w_pend_bt   = reg_bytes(r_paddr);
    assign w_acc_shift = {r_acc[7:0], w_b};
    assign w_resume    = (w_b == IDLE_BYTE) && r_pend;

    // A read command on the data register captures the live samples if marked valid.
    assign w_latch = (i_item.cmd == CMD_BYTE) && (r_phase == PH_IDLE) && !w_resume
                     && w_b[6] && (w_new_reg == REG_DATA) && i_item.samples_valid;

    always_comb begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (w_latch && i < NUM_INPUT_CH) begin
                n_store[i] = w_in_samples[i];
            end else begin
                n_store[i] = r_store[i];
            end
        end
    end

    // Channel picked by config; out-of-range channels read as zero.
    always_comb begin
        w_chan_val = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (r_config[2:0] == 3'(i)) begin
                w_chan_val = n_store[i];
            end
        end
    end

    always_comb begin
        w_val[REG_STATUS]    = {13'd0, r_config[2:0]};
        w_val[REG_MODE]      = r_mode;
        w_val[REG_CONFIG]    = r_config;
        w_val[REG_DATA]      = w_chan_val;
        w_val[REG_ID]        = {8'd0, r_id};
        w_val[REG_IO]        = {8'd0, r_io};
        w_val[REG_OFFSET]    = r_offset;
        w_val[REG_FULLSCALE] = r_fs;
    end

    always_comb begin
        n_phase  = r_phase;
        n_cur    = r_cur;
        n_bi     = r_bi;
        n_bt     = r_bt;
        n_acc    = r_acc;
        n_pend   = r_pend;
        n_paddr  = r_paddr;
        n_pi     = r_pi;
        n_out    = r_out;
        n_mode   = r_mode;
        n_config = r_config;
        n_io     = r_io;
        n_offset = r_offset;
        n_fs     = r_fs;
        case (i_item.cmd)
            CMD_BYTE: begin
                if (r_phase == PH_READ) begin
                    // Advance through the register's bytes, drop to idle after the last.
                    n_bi = w_bi_inc;
                    if (w_bi_inc < r_bt) begin
                        n_out = sel_byte(r_cur, w_bi_inc, w_val[r_cur]);
                    end else begin
                        n_phase = PH_IDLE;
                        n_out   = IDLE_BYTE;
                    end
                end else if (r_phase == PH_WRITE) begin
                    n_acc = w_acc_shift;
                    n_bi  = w_bi_inc;
                    if (w_bi_inc >= r_bt) begin
                        n_phase = PH_IDLE;
                        case (r_cur)
                            REG_MODE: begin
                                n_mode = w_acc_shift;
                            end
                            REG_CONFIG: begin
                                n_config = w_acc_shift;
                            end
                            REG_IO: begin
                                n_io = w_acc_shift[7:0];
                            end
                            REG_OFFSET: begin
                                n_offset = w_acc_shift;
                            end
                            REG_FULLSCALE: begin
                                n_fs = w_acc_shift;
                            end
                            default: begin
                            end
                        endcase
                    end
                end else if (w_resume) begin
                    n_phase = PH_READ;
                    n_bt    = w_pend_bt;
                    n_bi    = 2'd0;
                    if (w_pi_inc < w_pend_bt) begin
                        n_pi  = w_pi_inc;
                        n_out = sel_byte(r_paddr, w_pi_inc, w_val[r_paddr]);
                    end else begin
                        n_pend = 1'b0;
                        n_pi   = 2'd0;
                        n_out  = IDLE_BYTE;
                    end
                end else begin
                    // Communication byte.
                    n_cur = w_new_reg;
                    n_bi  = 2'd0;
                    n_bt  = reg_bytes(w_new_reg);
                    n_pi  = 2'd0;
                    if (w_b[6]) begin
                        n_pend  = 1'b1;
                        n_paddr = w_new_reg;
                        n_phase = PH_READ;
                        n_out   = sel_byte(w_new_reg, 2'd0, w_val[w_new_reg]);
                    end else begin
                        n_pend  = 1'b0;
                        n_phase = PH_WRITE;
                        n_acc   = '0;
                    end
                end
            end
            CMD_CS_ON: begin
                if (r_pend) begin
                    n_bt  = w_pend_bt;
                    n_out = sel_byte(r_paddr, r_pi, w_val[r_paddr]);
                end
            end
            CMD_CS_OFF: begin
                n_phase = PH_IDLE;
                n_out   = IDLE_BYTE;
            end
            default: begin
            end
        endcase
    end

    assign o_result.miso_byte = n_out;
    assign o_result.phase     = n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id     <= ID_RESET;
            r_phase  <= PH_IDLE;
            r_cur    <= '0;
            r_bi     <= '0;
            r_bt     <= '0;
            r_acc    <= '0;
            r_pend   <= 1'b0;
            r_paddr  <= '0;
            r_pi     <= '0;
            r_out    <= IDLE_BYTE;
            r_mode   <= MODE_RESET;
            r_config <= CONFIG_RESET;
            r_io     <= '0;
            r_offset <= OFFSET_RESET;
            r_fs     <= FULLSCALE_RESET;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_store[i] <= SAMPLE_RESET;
            end
        end else begin
            if (i_cfg_we) begin
                r_id <= i_cfg_data;
            end
            if (i_step) begin
                r_phase  <= n_phase;
                r_cur    <= n_cur;
                r_bi     <= n_bi;
                r_bt     <= n_bt;
                r_acc    <= n_acc;
                r_pend   <= n_pend;
                r_paddr  <= n_paddr;
                r_pi     <= n_pi;
                r_out    <= n_out;
                r_mode   <= n_mode;
                r_config <= n_config;
                r_io     <= n_io;
                r_offset <= n_offset;
                r_fs     <= n_fs;
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    r_store[i] <= n_store[i];
                end
            end
        end
    end

endmodule

// ----- src/adcspi_out_reg.sv -----
// ----------------------------------------------------------------------------
// adcspi_out_reg
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module adcspi_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  adcspi_pkg::t_result i_result,
    input  logic                i_ready,
    output logic                o_valid,
    output adcspi_pkg::t_result o_result
);
    import adcspi_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ----- src/adcspi_checker.sv -----
// ----------------------------------------------------------------------------
// adcspi_checker
// Port-level checks of the ADC SPI register block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adcspi_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_s_axis_tready,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic [1:0] o_m_axis_tuser
);
    import adcspi_pkg::*;

    // Reset empties the result register.
    `ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !o_m_axis_tvalid, "result valid after reset")

    // Input side backs up only behind a stalled, full result register.
    `ASSERT_ALWAYS(a_backpressure, i_clk, i_rst_n, o_s_axis_tready || (o_m_axis_tvalid && !i_m_axis_tready), "input stalled without output stall")

    // A stalled result holds.
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "stalled result changed")

    // Phase code stays within idle, reading and writing.
    `ASSERT_ALWAYS(a_phase_code, i_clk, i_rst_n, !o_m_axis_tvalid || o_m_axis_tuser == PH_IDLE || o_m_axis_tuser == PH_READ || o_m_axis_tuser == PH_WRITE, "bad phase code")

endmodule

bind adc_spi_register_interface_top adcspi_checker u_adcspi_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
